>>> src/dspm_pkg.sv
package dspm_pkg;

	localparam int MAX_PATTERN_DEFAULT = 32;

	localparam logic [7:0] STAR_SYM = 8'd42;
	localparam logic [7:0] ANY_SYM  = 8'd46;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_APPEND  = 2'd1,
		CMD_SUBJECT = 2'd2,
		CMD_REPORT  = 2'd3
	} command_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic append;
		logic start;
		logic step;
		logic report;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic len_zero;
		logic walk_last;
	} dp_status_t;

	function automatic logic elem_hits(input logic [7:0] pat, input logic [7:0] sym);
		return (pat == sym) || (pat == ANY_SYM);
	endfunction

endpackage

>>> src/dspm_if.sv
interface dspm_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] symbol;

	modport source (output valid, output command, output symbol, input ready);
	modport sink   (input valid, input command, input symbol, output ready);
endinterface

interface dspm_result_if;
	logic valid;
	logic ready;
	logic matched;
	logic overflow;

	modport source (output valid, output matched, output overflow, input ready);
	modport sink   (input valid, input matched, input overflow, output ready);
endinterface

>>> src/dspm_ctrl.sv
module dspm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            in_command,
	output logic                  in_ready,
	input  logic                  out_ready,
	output logic                  out_valid,
	input  dspm_pkg::dp_status_t  status,
	output dspm_pkg::dp_cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   is_report;

	assign is_report = (in_command == dspm_pkg::CMD_REPORT);
	// a report needs the result slot free or emptying this cycle
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready || !is_report);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.clear  = accept && (in_command == dspm_pkg::CMD_CLEAR);
		cmd.append = accept && (in_command == dspm_pkg::CMD_APPEND);
		cmd.start  = accept && (in_command == dspm_pkg::CMD_SUBJECT);
		cmd.report = accept && is_report;
		cmd.step   = (state_q == ST_WALK);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.start && !status.len_zero) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (status.walk_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.report) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

>>> src/dspm_datapath.sv
module dspm_datapath #(
	parameter int MAX_PATTERN = dspm_pkg::MAX_PATTERN_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            symbol,
	input  dspm_pkg::dp_cmd_t     cmd,
	output dspm_pkg::dp_status_t  status,
	output logic                  matched,
	output logic                  overflow
);

	localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
	localparam int ADDR_W = $clog2(MAX_PATTERN);
	localparam int ROW_W  = MAX_PATTERN + 1;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);
	localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
	localparam logic [LEN_W-1:0] LEN_TWO = LEN_W'(2);

	logic [7:0]       mem [MAX_PATTERN];
	logic [LEN_W-1:0] length_q;
	logic             overflow_flag_q;
	logic [ROW_W-1:0] empty_row_q;
	logic [ROW_W-1:0] match_row_q;
	logic [ROW_W-1:0] next_q;
	logic [LEN_W-1:0] j_q;
	logic [7:0]       sym_q;
	logic [7:0]       prev_q;
	logic [7:0]       rd_data_q;
	logic             matched_q;
	logic             overflow_q;

	logic [ADDR_W-1:0] rd_addr;
	logic              full;
	logic [LEN_W-1:0]  new_len;
	logic [LEN_W-1:0]  new_len_m2;
	logic [ROW_W-1:0]  empty_next;
	logic [LEN_W-1:0]  jm1;
	logic [LEN_W-1:0]  jm2;
	logic              bit_j;
	logic [ROW_W-1:0]  next_full;

	assign full            = (length_q >= LEN_MAX);
	assign new_len         = length_q + LEN_ONE;
	assign new_len_m2      = (new_len >= LEN_TWO) ? (new_len - LEN_TWO) : '0;
	assign status.len_zero  = (length_q == '0);
	assign status.walk_last = (j_q == length_q);
	assign matched         = matched_q;
	assign overflow        = overflow_q;

	// empty-subject column for the symbol being appended
	always_comb begin
		empty_next = empty_row_q;
		if (!full) begin
			if (symbol != dspm_pkg::STAR_SYM || new_len < LEN_TWO) empty_next[new_len] = 1'b0;
			else empty_next[new_len] = empty_row_q[new_len_m2];
		end
	end

	// one pattern position per walk cycle; rd_data_q holds store[j-1], prev_q store[j-2]
	assign jm1 = j_q - LEN_ONE;
	assign jm2 = (j_q >= LEN_TWO) ? (j_q - LEN_TWO) : '0;

	always_comb begin
		if (rd_data_q != dspm_pkg::STAR_SYM)
			bit_j = match_row_q[jm1] && dspm_pkg::elem_hits(rd_data_q, sym_q);
		else if (j_q < LEN_TWO)
			bit_j = 1'b0;
		else if (dspm_pkg::elem_hits(prev_q, sym_q))
			bit_j = match_row_q[j_q] || next_q[jm2];
		else
			bit_j = next_q[jm2];
		next_full      = next_q;
		next_full[j_q] = bit_j;
	end

	assign rd_addr = (cmd.start || j_q >= LEN_MAX) ? '0 : j_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (cmd.append && !full) mem[length_q[ADDR_W-1:0]] <= symbol;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sym_q  <= symbol;
			j_q    <= LEN_ONE;
			next_q <= '0;
		end else if (cmd.step) begin
			prev_q <= rd_data_q;
			j_q    <= j_q + LEN_ONE;
			next_q <= next_full;
		end
		if (cmd.report) begin
			matched_q  <= match_row_q[length_q];
			overflow_q <= overflow_flag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q        <= '0;
			overflow_flag_q <= 1'b0;
			empty_row_q     <= ROW_W'(1);
			match_row_q     <= ROW_W'(1);
		end else begin
			if (cmd.clear) begin
				length_q        <= '0;
				overflow_flag_q <= 1'b0;
				empty_row_q     <= ROW_W'(1);
				match_row_q     <= ROW_W'(1);
			end else if (cmd.append) begin
				if (full) overflow_flag_q <= 1'b1;
				else length_q <= new_len;
				empty_row_q <= empty_next;
				match_row_q <= empty_next;
			end else if (cmd.start && status.len_zero) begin
				match_row_q <= '0;
			end else if (cmd.step && status.walk_last) begin
				match_row_q <= next_full;
			end else if (cmd.report) begin
				match_row_q <= empty_row_q;
			end
		end
	end

endmodule

>>> src/dot_star_pattern_matcher.sv
// Whole-string matcher for patterns of literal bytes, '.' and '*'.
// item channel (sink): command + symbol. Clear drops the pattern and the
//   overflow flag; append adds one pattern byte (past capacity the byte is
//   dropped and the flag set); subject feeds one subject byte; report ends
//   the subject.  An append also restarts any subject in progress.
// result channel (source): one word per report, matched and overflow.
// A subject byte on a non-empty pattern starts a walk: the row update walks
//   the pattern one position a cycle through the single read port of the
//   pattern store, since a star bit depends on lower bits of the same new
//   row.  Item ready is low during the walk.
// The result word appears the cycle after its report is accepted and sits
//   in an output register.  While the receiver stalls, other items are still
//   taken; a further report waits until the held word is taken.
// Reset (arst_n low) empties the pattern, clears the flag and the rows and
//   drops any pending result.  Pattern store contents are undefined until
//   written, and only written entries feed the row update.
module dot_star_pattern_matcher #(
	parameter int MAX_PATTERN = dspm_pkg::MAX_PATTERN_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	dspm_item_if.sink      item,
	dspm_result_if.source  result
);

	dspm_pkg::dp_cmd_t    cmd;
	dspm_pkg::dp_status_t status;

	// sequencing: handshakes and walk control
	dspm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item.valid),
		.in_command (item.command),
		.in_ready   (item.ready),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.status     (status),
		.cmd        (cmd)
	);

	// pattern store, match rows and result register
	dspm_datapath #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.symbol   (item.symbol),
		.cmd      (cmd),
		.status   (status),
		.matched  (result.matched),
		.overflow (result.overflow)
	);

endmodule

>>> bench/tb_dot_star_pattern_matcher.sv
module tb_dot_star_pattern_matcher;

	localparam int CLK_PERIOD    = 10;
	localparam int PATTERN_CAP   = dspm_pkg::MAX_PATTERN_DEFAULT;
	// a subject byte holds the block for a walk over the pattern; leave some slack on top
	localparam int SETTLE_CYCLES = PATTERN_CAP + 8;
	localparam int RANDOM_ITEMS  = 600;
	localparam int DRAIN_EVERY   = 150;
	// slowest run: ~1000 words, each with the longest source gap, a walk over
	// a full pattern and the longest receiver stall, taken several times over
	localparam int CYCLE_LIMIT   = 500000;

	typedef logic [7:0] sym_q_t [$];

	typedef struct packed {
		logic matched;
		logic overflow;
	} report_t;

	logic clk = 1'b0;
	logic arst_n;

	dspm_item_if   item_ch ();
	dspm_result_if result_ch ();

	dot_star_pattern_matcher #(
		.MAX_PATTERN(PATTERN_CAP)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow copy of the matcher: pattern bytes, length, the row for the
	// empty subject, the live row and the overflow flag.
	logic [7:0]         model_pattern [PATTERN_CAP];
	int                 model_length;
	logic [PATTERN_CAP:0] model_empty_row;
	logic [PATTERN_CAP:0] model_row;
	logic               model_overflow;

	// reports accepted by the block whose result words have not come yet
	report_t pending_reports [$];

	// pattern as the stimulus side knows it, used to build matching subjects
	sym_q_t pattern_q;

	int  cycle_count     = 0;
	int  items_sent      = 0;
	int  reports_checked = 0;
	int  matches_seen    = 0;
	int  overflows_seen  = 0;
	int  mismatch_count  = 0;
	bit  source_stalls   = 1'b1;
	bit  sink_stalls     = 1'b1;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic void clear_model();
		model_length       = 0;
		model_overflow     = 1'b0;
		model_empty_row    = '0;
		model_empty_row[0] = 1'b1;
		model_row          = model_empty_row;
	endfunction

	// Advance the row by one subject byte. Walk positions upward: a star
	// bit reuses the bit two below it in the new row.
	function automatic logic [PATTERN_CAP:0] next_match_row(input logic [7:0] sym);
		logic [PATTERN_CAP:0] nxt;
		logic [7:0]           pat;
		logic                 prev_hit;
		int                   j;
		nxt = '0;
		for (j = 1; j <= model_length; j++) begin
			pat = model_pattern[j - 1];
			if (pat != dspm_pkg::STAR_SYM) begin
				nxt[j] = model_row[j - 1] && (pat == sym || pat == dspm_pkg::ANY_SYM);
			end else if (j < 2) begin
				// leading star has no element to repeat
				nxt[j] = 1'b0;
			end else begin
				// the element before a star is compared as a plain byte,
				// even when it is a star itself
				prev_hit = (model_pattern[j - 2] == sym) ||
				           (model_pattern[j - 2] == dspm_pkg::ANY_SYM);
				nxt[j] = prev_hit ? (model_row[j] || nxt[j - 2]) : nxt[j - 2];
			end
		end
		return nxt;
	endfunction

	// Apply one accepted word to the shadow state; queue a report if due.
	function automatic void advance_matcher(input dspm_pkg::command_t cmd,
	                                        input logic [7:0] sym);
		report_t rep;
		case (cmd)
			dspm_pkg::CMD_CLEAR: begin
				clear_model();
			end
			dspm_pkg::CMD_APPEND: begin
				if (model_length >= PATTERN_CAP) begin
					// drop the byte, remember the loss
					model_overflow = 1'b1;
				end else begin
					model_pattern[model_length] = sym;
					model_length++;
					if (sym != dspm_pkg::STAR_SYM || model_length < 2)
						model_empty_row[model_length] = 1'b0;
					else
						model_empty_row[model_length] = model_empty_row[model_length - 2];
				end
				// any subject in progress is thrown away
				model_row = model_empty_row;
			end
			dspm_pkg::CMD_SUBJECT: begin
				model_row = next_match_row(sym);
			end
			default: begin
				rep.matched  = model_row[model_length];
				rep.overflow = model_overflow;
				pending_reports.push_back(rep);
				model_row = model_empty_row;
			end
		endcase
	endfunction

	function automatic void log_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endfunction

	// Mostly a small alphabet so that literals, dots and stars interact;
	// now and then any byte at all.
	function automatic logic [7:0] pattern_byte();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1, 2: return "a";
			3:       return "b";
			4, 5:    return dspm_pkg::ANY_SYM;
			6, 7:    return dspm_pkg::STAR_SYM;
			8:       return "c";
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] subject_byte();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1, 2: return "a";
			3, 4:    return "b";
			5:       return "c";
			6:       return dspm_pkg::STAR_SYM;
			7:       return dspm_pkg::ANY_SYM;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Expand the current pattern into a subject it should accept: repeat a
	// starred element 0..3 times, fill dots with any byte, skip stray stars.
	function automatic void make_matching_subject(output sym_q_t subj);
		int         i;
		int         reps;
		logic [7:0] c;
		subj = {};
		i = 0;
		while (i < pattern_q.size()) begin
			c = pattern_q[i];
			if (i + 1 < pattern_q.size() && pattern_q[i + 1] == dspm_pkg::STAR_SYM) begin
				reps = $urandom_range(0, 3);
				repeat (reps) subj.push_back((c == dspm_pkg::ANY_SYM) ? subject_byte() : c);
				i += 2;
			end else if (c == dspm_pkg::STAR_SYM) begin
				i++;
			end else begin
				subj.push_back((c == dspm_pkg::ANY_SYM) ? subject_byte() : c);
				i++;
			end
		end
	endfunction

	// Send one word: wait a random gap with valid low, then hold it until
	// the block takes it. Valid stays high afterwards; the next word or
	// go_idle decides what happens at the following falling edge.
	task automatic send_word(input dspm_pkg::command_t cmd, input logic [7:0] sym);
		int gap;
		gap = source_stalls ? $urandom_range(0, 14) : 0;
		@(negedge clk);
		repeat (gap) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.command <= cmd;
		item_ch.symbol  <= sym;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		advance_matcher(cmd, sym);
		items_sent++;
	endtask

	task automatic go_idle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
	endtask

	// Hold the sender until every report has come back, then let any
	// trailing subject walk finish before the next phase.
	task automatic wait_for_reports();
		go_idle();
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_subject(input sym_q_t subj);
		int k;
		for (k = 0; k < subj.size(); k++) send_word(dspm_pkg::CMD_SUBJECT, subj[k]);
		send_word(dspm_pkg::CMD_REPORT, 8'($urandom_range(0, 255)));
	endtask

	task automatic load_pattern(input int plen);
		logic [7:0] sym;
		pattern_q = {};
		send_word(dspm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
		repeat (plen) begin
			sym = pattern_byte();
			if (pattern_q.size() < PATTERN_CAP) pattern_q.push_back(sym);
			send_word(dspm_pkg::CMD_APPEND, sym);
		end
	endtask

	// Hand-picked cases: empty pattern, byte extremes, dot-star, leading
	// star, star after star and an append in the middle of a subject.
	task automatic test_directed();
		send_word(dspm_pkg::CMD_REPORT, 8'h00);           // empty subject, empty pattern
		send_word(dspm_pkg::CMD_SUBJECT, 8'hFF);
		send_word(dspm_pkg::CMD_REPORT, 8'hFF);
		send_word(dspm_pkg::CMD_APPEND, 8'h00);
		send_word(dspm_pkg::CMD_SUBJECT, 8'h00);
		send_word(dspm_pkg::CMD_REPORT, 8'h00);
		send_word(dspm_pkg::CMD_CLEAR, 8'hFF);
		send_word(dspm_pkg::CMD_APPEND, dspm_pkg::ANY_SYM);
		send_word(dspm_pkg::CMD_APPEND, dspm_pkg::STAR_SYM);
		send_word(dspm_pkg::CMD_REPORT, 8'h00);           // dot-star takes the empty subject
		send_word(dspm_pkg::CMD_SUBJECT, 8'hFF);
		send_word(dspm_pkg::CMD_REPORT, 8'h00);
		send_word(dspm_pkg::CMD_CLEAR, 8'h00);
		send_word(dspm_pkg::CMD_APPEND, dspm_pkg::STAR_SYM); // star with nothing before it
		send_word(dspm_pkg::CMD_REPORT, 8'h00);
		send_word(dspm_pkg::CMD_CLEAR, 8'h00);
		send_word(dspm_pkg::CMD_APPEND, "a");
		send_word(dspm_pkg::CMD_APPEND, dspm_pkg::STAR_SYM);
		send_word(dspm_pkg::CMD_APPEND, dspm_pkg::STAR_SYM); // repeats a literal star byte
		send_word(dspm_pkg::CMD_SUBJECT, dspm_pkg::STAR_SYM);
		send_word(dspm_pkg::CMD_SUBJECT, "a");
		send_word(dspm_pkg::CMD_APPEND, 8'hFF);           // restarts the subject
		send_word(dspm_pkg::CMD_REPORT, 8'h00);
		wait_for_reports();
	endtask

	// Fill the pattern store to the top and push up to three bytes past it, then
	// run a matching subject across the full length.
	task automatic test_capacity();
		sym_q_t     subj;
		logic [7:0] sym;
		int         round;
		int         k;
		for (round = 0; round < 4; round++) begin
			source_stalls = (round != 1);
			pattern_q = {};
			send_word(dspm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
			for (k = 0; k < PATTERN_CAP + round; k++) begin
				sym = (round == 3) ? 8'($urandom_range(0, 255)) : pattern_byte();
				if (k < PATTERN_CAP) pattern_q.push_back(sym);
				send_word(dspm_pkg::CMD_APPEND, sym);
			end
			make_matching_subject(subj);
			run_subject(subj);
			send_word(dspm_pkg::CMD_REPORT, 8'($urandom_range(0, 255)));
		end
		wait_for_reports();
	endtask

	// Sessions of clear + pattern + several subjects, most of them built
	// to match, some mutated or purely random, some cut by an append, with
	// bursts of random words mixed in.
	task automatic test_random_sessions();
		sym_q_t     subj;
		logic [7:0] sym;
		int         start_count;
		int         last_drain;
		int         plen;
		int         n;
		int         cut;
		int         k;
		start_count = items_sent;
		last_drain  = items_sent;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			source_stalls = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 6);
				repeat (n) send_word(dspm_pkg::command_t'($urandom_range(0, 3)),
				                     8'($urandom_range(0, 255)));
			end else begin
				plen = ($urandom_range(0, 9) == 0) ? $urandom_range(8, PATTERN_CAP + 2)
				                                   : $urandom_range(0, 7);
				load_pattern(plen);
				n = $urandom_range(1, 4);
				repeat (n) begin
					if ($urandom_range(0, 2) != 0) begin
						make_matching_subject(subj);
						case ($urandom_range(0, 5))
							0: if (subj.size() > 0)
								subj[$urandom_range(0, subj.size() - 1)] = subject_byte();
							1: subj.push_back(subject_byte());
							default: ;
						endcase
					end else begin
						subj = {};
						repeat ($urandom_range(0, 8)) subj.push_back(subject_byte());
					end
					if ($urandom_range(0, 7) == 0 && subj.size() > 0) begin
						// break the subject with an append, then start over
						cut = $urandom_range(0, subj.size() - 1);
						for (k = 0; k < cut; k++) send_word(dspm_pkg::CMD_SUBJECT, subj[k]);
						sym = pattern_byte();
						if (pattern_q.size() < PATTERN_CAP) pattern_q.push_back(sym);
						send_word(dspm_pkg::CMD_APPEND, sym);
						make_matching_subject(subj);
					end
					run_subject(subj);
				end
			end
			if (items_sent - last_drain >= DRAIN_EVERY) begin
				wait_for_reports();
				last_drain = items_sent;
			end
		end
		wait_for_reports();
	endtask

	// Result side: draw a stall for each word, then take it and check it
	// against the oldest pending report.
	initial begin : report_checker
		int      stall;
		report_t want;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = sink_stalls ? $urandom_range(0, 14) : 0;
			@(negedge clk);
			repeat (stall) begin
				result_ch.ready <= 1'b0;
				@(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk);
			while (!(result_ch.valid === 1'b1 && result_ch.ready === 1'b1));
			if (pending_reports.size() == 0) begin
				log_mismatch($sformatf("result word with no report pending: matched=%b overflow=%b",
					result_ch.matched, result_ch.overflow));
			end else begin
				want = pending_reports.pop_front();
				reports_checked++;
				if (want.matched)  matches_seen++;
				if (want.overflow) overflows_seen++;
				if (result_ch.matched !== want.matched)
					log_mismatch($sformatf("report %0d matched: expected %b, got %b",
						reports_checked, want.matched, result_ch.matched));
				if (result_ch.overflow !== want.overflow)
					log_mismatch($sformatf("report %0d overflow: expected %b, got %b",
						reports_checked, want.overflow, result_ch.overflow));
			end
			if ($urandom_range(0, 19) == 0) sink_stalls = ~sink_stalls;
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d reports still pending",
			cycle_count, pending_reports.size());
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.command = dspm_pkg::CMD_CLEAR;
		item_ch.symbol  = 8'h00;
		clear_model();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_capacity();
		test_random_sessions();

		$display("sent %0d words, checked %0d reports (%0d matched, %0d overflowed), %0d mismatches",
			items_sent, reports_checked, matches_seen, overflows_seen, mismatch_count);
		$display("covered empty and full patterns, dropped appends, leading and doubled stars,");
		$display("appends inside a subject and random gaps on both channels");
		if (mismatch_count == 0 && pending_reports.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
